// ----- rtl/jtsh_pkg.sv -----
// Shared types and constants for the JSON token splitter with hash.
// Used by jtsh_out and json_token_splitter_with_hash; no dependencies.
package jtsh_pkg;

  localparam int NRES  = 6;
  localparam int CNT_W = 3;

  localparam logic [31:0] HASH_MULT = 32'h0100_0193;
  localparam logic [31:0] HASH_SEED = 32'h811c_9dc5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CUT  = 2'd1,
    ERR_UTF8 = 2'd2,
    ERR_LINE = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0]  tok;
    kind_t       kind;
    err_t        err;
    logic [15:0] line;
  } ent_t;

  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] cnt;
  } ld_t;

endpackage

// ----- rtl/json_token_splitter_with_hash.sv -----
// Whitespace tokenizer with FNV-1a 32-bit token hash: per-byte step logic and state.
// Depends on jtsh_pkg and jtsh_out.
//
// Input channel (in_valid/in_ready): one text byte per word, in_end_of_data on the
// last byte of a stream. Result channel (out_valid/out_ready): one word per result,
// token bytes, token ends with hash, or error reports; out_last_of_run marks the
// final word caused by one input byte.
// The first result of a byte shows on the output in the cycle after the byte is
// taken. A byte that gives no result leaves in_ready high; a byte that gives
// results holds the input until the single result buffer, drained one word per
// cycle while the receiver takes them, is down to its last word. The next byte is
// taken in the same cycle as the last word of the previous one leaves.
// The FNV-1a hash is folded in one byte per cycle as the receiver takes token bytes.
// Reset (synchronous, active low) returns the control state and hash to the start
// of a stream; there is no clearing pass. After a line-too-long report the block
// keeps taking bytes but gives no results until reset. When the receiver stalls, the
// buffered results hold; in_ready is high only while the buffer is empty or its
// last word leaves in that cycle.
module json_token_splitter_with_hash
  import jtsh_pkg::*;
#(
  parameter int TOKEN_MAX = 64,
  parameter int LINE_MAX  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_token_byte,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_token_hash,
  output logic [15:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  localparam int TF_W  = $clog2(TOKEN_MAX + 1);
  localparam int SUM_W = $clog2(TOKEN_MAX + 5);
  localparam int LF_W  = $clog2(LINE_MAX + 1);

  typedef struct packed {
    logic            quote;
    logic            active;
    logic            slash;
    logic            skip;
    logic [TF_W-1:0] tfill;
    logic [LF_W-1:0] lfill;
    logic [15:0]     line;
    logic [2:0]      need;
    logic [2:0]      have;
    logic            halted;
  } st_t;

  typedef struct packed {
    st_t              st;
    logic [3:0][7:0]  cb;
    logic [CNT_W-1:0] n;
    ent_t [NRES-1:0]  lst;
  } wk_t;

  st_t             st_r;
  logic [3:0][7:0] cb_r;
  wk_t             w;
  logic            acc;
  logic            can_load;
  ld_t             load;

  function automatic logic [2:0] f_lead(logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)          len = 3'd1;
    else if (b[7:5] == 3'b110)          len = 3'd2;
    else if (b[7:4] == 4'b1110)         len = 3'd3;
    else if (b[7:3] == 5'b11110)        len = 3'd4;
    else                                len = 3'd1;
    return len;
  endfunction

  function automatic wk_t f_emit(wk_t wi, logic [7:0] tok, kind_t kind, err_t err);
    wk_t wo;
    wo = wi;
    if (wo.n < CNT_W'(NRES)) begin
      wo.lst[wo.n] = '{tok: tok, kind: kind, err: err, line: wo.st.line};
      wo.n = wo.n + CNT_W'(1);
    end
    return wo;
  endfunction

  function automatic wk_t f_end(wk_t wi);
    wk_t wo;
    wo = wi;
    if (wo.st.active) wo = f_emit(wo, 8'd0, KIND_END, ERR_NONE);
    wo.st.active = 1'b0;
    wo.st.tfill  = '0;
    wo.st.quote  = 1'b0;
    return wo;
  endfunction

  function automatic wk_t f_commit(wk_t wi);
    wk_t              wo;
    logic [2:0]       len;
    logic [SUM_W-1:0] sum;
    wo = wi;
    len = wo.st.need;
    wo.st.need = '0;
    wo.st.have = '0;
    sum = SUM_W'(wo.st.tfill) + SUM_W'(len);
    if (sum > SUM_W'(TOKEN_MAX)) begin
      // character does not fit: drop it and close the token
      wo = f_emit(wo, 8'd0, KIND_ERR, ERR_CUT);
      wo = f_end(wo);
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < len) wo = f_emit(wo, wo.cb[i], KIND_BYTE, ERR_NONE);
      end
      wo.st.active = 1'b1;
      wo.st.tfill  = TF_W'(sum);
      if (sum >= SUM_W'(TOKEN_MAX)) begin
        wo = f_emit(wo, 8'd0, KIND_ERR, ERR_CUT);
        wo = f_end(wo);
      end
    end
    return wo;
  endfunction

  function automatic wk_t f_flush(wk_t wi);
    wk_t wo;
    wo = wi;
    wo.st.slash = 1'b0;
    wo.cb[0]    = CH_SLASH;
    wo.st.need  = 3'd1;
    wo.st.have  = 3'd1;
    return f_commit(wo);
  endfunction

  function automatic wk_t f_drop(wk_t wi);
    wk_t wo;
    wo = wi;
    if (wo.st.need != '0) begin
      wo = f_emit(wo, 8'd0, KIND_ERR, ERR_UTF8);
      wo.st.need = '0;
      wo.st.have = '0;
    end
    return wo;
  endfunction

  // one input byte: next state and the ordered list of results it causes
  always_comb begin
    logic [7:0] b;
    logic       nl;
    logic       done;
    b    = in_data_byte;
    if (b == CH_TAB || b == CH_CR) b = CH_SPACE;
    nl   = (b == CH_NL);
    done = 1'b0;
    w.st  = st_r;
    w.cb  = cb_r;
    w.n   = '0;
    w.lst = '0;
    if (!st_r.halted) begin
      if (!nl) begin
        w.st.lfill = st_r.lfill + LF_W'(1);
        if (w.st.lfill >= LF_W'(LINE_MAX)) begin
          w.st.halted = 1'b1;
          w = f_emit(w, 8'd0, KIND_ERR, ERR_LINE);
          done = 1'b1;
        end
      end
      if (!done) begin
        if (w.st.slash) begin
          if (b == CH_SLASH) begin
            // second slash: drop the rest of the line
            w.st.slash = 1'b0;
            w.st.skip  = 1'b1;
            b  = 8'd0;
            nl = 1'b0;
          end else begin
            w = f_flush(w);
          end
        end

        if (w.st.skip) begin
          if (nl) w.st.skip = 1'b0;
        end else if (w.st.need != '0) begin
          if (nl) begin
            w = f_drop(w);
            w = f_end(w);
          end else begin
            w.cb[w.st.have[1:0]] = b;
            w.st.have = w.st.have + 3'd1;
            if (w.st.have >= w.st.need) w = f_commit(w);
          end
        end else if (nl) begin
          w = f_end(w);
        end else if (b == CH_SPACE && !w.st.quote) begin
          w = f_end(w);
        end else if (!w.st.active && b == CH_SLASH) begin
          w.st.slash = 1'b1;
        end else begin
          if (b == CH_QUOTE) w.st.quote = ~w.st.quote;
          w.cb[0]    = b;
          w.st.have  = 3'd1;
          w.st.need  = f_lead(b);
          if (w.st.need == 3'd1) w = f_commit(w);
        end

        if (nl) begin
          w.st.line  = w.st.line + 16'd1;
          w.st.lfill = '0;
        end

        if (in_end_of_data) begin
          if (w.st.slash) w = f_flush(w);
          w = f_drop(w);
          w = f_end(w);
          w.st = '0;
        end
      end
    end
  end

  assign in_ready = can_load;
  assign acc      = in_valid && in_ready;
  assign load     = '{vld: acc && (w.n != '0), cnt: w.n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (acc) begin
      st_r <= w.st;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cb_r <= w.cb;
    end
  end

  jtsh_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .ents            (w.lst),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_byte  (out_token_byte),
    .out_result_kind (out_result_kind),
    .out_token_hash  (out_token_hash),
    .out_line_number (out_line_number),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- rtl/jtsh_out.sv -----
// Result buffer and drain for the token splitter: holds the words of one input byte,
// hands them out one per cycle unless stalled, keeps the FNV-1a hash; uses jtsh_pkg.
module jtsh_out
  import jtsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ld_t              load,
  input  ent_t [NRES-1:0]  ents,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_token_byte,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_token_hash,
  output logic [15:0]      out_line_number,
  output logic [1:0]       out_error_code,
  output logic             out_last_of_run
);

  ent_t [NRES-1:0]  ent_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] rd_r;
  logic [31:0]      hash_r;
  logic [31:0]      hash_nxt;
  ent_t             head;
  logic             pop;

  assign head      = ent_r[rd_r];
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  assign out_token_byte  = head.tok;
  assign out_result_kind = head.kind;
  assign out_token_hash  = (head.kind == KIND_END) ? hash_r : 32'd0;
  assign out_line_number = head.line;
  assign out_error_code  = head.err;
  assign out_last_of_run = (cnt_r == CNT_W'(1));

  // fold each byte into the hash as it leaves; a token end restarts it
  always_comb begin
    hash_nxt = hash_r;
    if (pop) begin
      unique case (head.kind)
        KIND_BYTE: hash_nxt = (hash_r ^ {24'd0, head.tok}) * HASH_MULT;
        KIND_END:  hash_nxt = HASH_SEED;
        default:   hash_nxt = hash_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rd_r   <= '0;
      hash_r <= HASH_SEED;
    end else begin
      hash_r <= hash_nxt;
      if (load.vld) begin
        cnt_r <= load.cnt;
        rd_r  <= '0;
      end else if (pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
        rd_r  <= (cnt_r == CNT_W'(1)) ? '0 : rd_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.vld) begin
      ent_r <= ents;
    end
  end

endmodule
